// File: hw/rtl/mmcv_pkg.sv
package mmcv_pkg;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LINE_W   = 9;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned NBANK    = 8;

    // command codes carried on tuser
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PRG   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHR   = 3'd4;

    // configuration register indexes
    localparam logic CFG_FOUR_SCREEN = 1'b0;
    localparam logic CFG_HDR_MIRROR  = 1'b1;

    localparam logic [ADDR_W-1:0] EXT_LO = 16'h5000;
    localparam logic [ADDR_W-1:0] EXT_HI = 16'h5007;
    localparam logic [LINE_W-1:0] LAST_VISIBLE = 9'd239;
    localparam logic [3:0] PRG_SECOND_LAST = 4'hE;
    localparam logic [3:0] PRG_LAST        = 4'hF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EXT_WRITE,
        OP_BANK_SEL,
        OP_BANK_DATA,
        OP_MIRROR,
        OP_IRQ_LATCH,
        OP_IRQ_RELOAD,
        OP_IRQ_DISABLE,
        OP_IRQ_ENABLE,
        OP_READ_HIT,
        OP_TICK,
        OP_PRG,
        OP_CHR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [2:0]       slot;
        logic [BYTE_W-1:0] data;
        logic             line_zero;
    } t_item;

    typedef struct packed {
        logic             mirror_horizontal;
        logic             irq_pending;
        logic [7:0]       chr_bank;
        logic [3:0]       prg_bank;
        logic             read_hit;
        logic [7:0]       read_data;
    } t_result;

    function automatic logic [BYTE_W-1:0] prot_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            3'd3:    v = 8'h01;
            3'd4:    v = 8'h02;
            3'd5:    v = 8'h04;
            3'd6:    v = 8'h0F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] bank_reset(input logic [2:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd2;
            3'd2:    v = 8'd4;
            3'd3:    v = 8'd5;
            3'd4:    v = 8'd6;
            3'd5:    v = 8'd7;
            3'd6:    v = 8'd0;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/mmcv_front.sv
module mmcv_front (
    input  logic [mmcv_pkg::CMD_W-1:0]  i_cmd,
    input  logic [mmcv_pkg::ADDR_W-1:0] i_addr,
    input  logic [mmcv_pkg::BYTE_W-1:0] i_data,
    input  logic [mmcv_pkg::LINE_W-1:0] i_line,
    input  logic                        i_display_on,
    output mmcv_pkg::t_item             o_item
);
    import mmcv_pkg::*;

    logic ext_hit;

    assign ext_hit = (i_addr inside {[EXT_LO:EXT_HI]});

    always_comb begin
        o_item.op        = OP_NONE;
        o_item.slot      = 3'd0;
        o_item.data      = i_data;
        o_item.line_zero = (i_line == '0);
        case (i_cmd)
            CMD_WRITE: begin
                if (ext_hit) begin
                    // only the first extension register has any effect
                    if (i_addr[2:0] == 3'd0) o_item.op = OP_EXT_WRITE;
                end else if (i_addr[15]) begin
                    case ({i_addr[14:13], i_addr[0]})
                        3'b000:  o_item.op = OP_BANK_SEL;
                        3'b001:  o_item.op = OP_BANK_DATA;
                        3'b010:  o_item.op = OP_MIRROR;
                        3'b100:  o_item.op = OP_IRQ_LATCH;
                        3'b101:  o_item.op = OP_IRQ_RELOAD;
                        3'b110:  o_item.op = OP_IRQ_DISABLE;
                        3'b111:  o_item.op = OP_IRQ_ENABLE;
                        default: o_item.op = OP_NONE;
                    endcase
                end
            end
            CMD_READ: begin
                if (ext_hit) begin
                    o_item.op   = OP_READ_HIT;
                    o_item.data = prot_byte(i_addr[2:0]);
                end
            end
            CMD_TICK: begin
                if (i_display_on && (i_line <= LAST_VISIBLE)) o_item.op = OP_TICK;
            end
            CMD_PRG: begin
                if (i_addr[15]) begin
                    o_item.op   = OP_PRG;
                    o_item.slot = {1'b0, i_addr[14:13]};
                end
            end
            CMD_CHR: begin
                if (i_addr[15:13] == 3'd0) begin
                    o_item.op   = OP_CHR;
                    o_item.slot = i_addr[12:10];
                end
            end
            default: o_item.op = OP_NONE;
        endcase
    end

endmodule

// File: hw/rtl/mmcv_queue.sv
module mmcv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mmcv_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mmcv_pkg::t_item o_item
);
    import mmcv_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

// File: hw/rtl/mmcv_back.sv
module mmcv_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic                        i_cfg_wdata,
    input  logic                        i_valid,
    input  mmcv_pkg::t_item             i_item,
    output logic                        o_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output mmcv_pkg::t_result           o_result
);
    import mmcv_pkg::*;

    logic [BYTE_W-1:0] r_bank [NBANK];
    logic [BYTE_W-1:0] r_bank_sel;
    logic [BYTE_W-1:0] r_ext_mode;
    logic              r_mirror, n_mirror;
    logic              r_four_screen;
    logic [BYTE_W-1:0] r_irq_cnt, n_irq_cnt;
    logic [BYTE_W-1:0] r_irq_reload;
    logic              r_irq_en, n_irq_en;
    logic              r_irq_blocked, n_irq_blocked;
    logic              r_irq_line, n_irq_line;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [BYTE_W-1:0] tick_cnt;
    logic              tick_fire;
    logic [3:0]        prg;
    logic [2:0]        ext_b;
    logic [2:0]        chr_slot;
    logic [7:0]        chr;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // prg translation
    always_comb begin
        ext_b = r_ext_mode[2:0];
        if (r_ext_mode[7]) begin
            if (r_ext_mode[5]) prg = {ext_b[2:1], i_item.slot[1:0]};
            else               prg = {ext_b, i_item.slot[0]};
        end else begin
            case (i_item.slot[1:0])
                2'd0:    prg = r_bank_sel[6] ? PRG_SECOND_LAST : r_bank[6][3:0];
                2'd1:    prg = r_bank[7][3:0];
                2'd2:    prg = r_bank_sel[6] ? r_bank[6][3:0] : PRG_SECOND_LAST;
                default: prg = PRG_LAST;
            endcase
        end
    end

    // chr translation, upper and lower halves swap on select bit 7
    always_comb begin
        chr_slot = i_item.slot ^ {r_bank_sel[7], 2'b00};
        case (chr_slot)
            3'd0:    chr = {r_bank[0][7:1], 1'b0};
            3'd1:    chr = {r_bank[0][7:1], 1'b1};
            3'd2:    chr = {r_bank[1][7:1], 1'b0};
            3'd3:    chr = {r_bank[1][7:1], 1'b1};
            default: chr = r_bank[chr_slot - 3'd2];
        endcase
    end

    // scanline counter
    always_comb begin
        tick_cnt = r_irq_cnt;
        if (i_item.line_zero && (tick_cnt != '0)) tick_cnt = tick_cnt - 8'd1;
        tick_fire = (tick_cnt == '0);
        if (tick_fire) tick_cnt = r_irq_reload;
        tick_cnt = tick_cnt - 8'd1;
    end

    always_comb begin
        n_mirror      = r_mirror;
        n_irq_cnt     = r_irq_cnt;
        n_irq_en      = r_irq_en;
        n_irq_blocked = r_irq_blocked;
        n_irq_line    = r_irq_line;
        n_out         = '0;
        if (o_take) begin
            case (i_item.op)
                OP_MIRROR: begin
                    if (!r_four_screen) n_mirror = i_item.data[0];
                end
                OP_IRQ_LATCH: begin
                    n_irq_blocked = 1'b0;
                    n_irq_cnt     = i_item.data;
                end
                OP_IRQ_RELOAD:  n_irq_blocked = 1'b0;
                OP_IRQ_DISABLE: begin
                    n_irq_blocked = 1'b0;
                    n_irq_en      = 1'b0;
                    n_irq_line    = 1'b0;
                end
                OP_IRQ_ENABLE: begin
                    n_irq_blocked = 1'b0;
                    n_irq_en      = 1'b1;
                end
                OP_TICK: begin
                    if (r_irq_en && !r_irq_blocked) begin
                        n_irq_cnt = tick_cnt;
                        if (tick_fire) begin
                            n_irq_blocked = 1'b1;
                            n_irq_line    = 1'b1;
                        end
                    end
                end
                OP_READ_HIT: begin
                    n_out.read_hit  = 1'b1;
                    n_out.read_data = i_item.data;
                end
                OP_PRG:  n_out.prg_bank = prg;
                OP_CHR:  n_out.chr_bank = chr;
                default: n_out.read_hit = 1'b0;
            endcase
        end
        if (i_cfg_wr_en && (i_cfg_index == CFG_HDR_MIRROR)) n_mirror = i_cfg_wdata;
        n_out.irq_pending       = n_irq_line;
        n_out.mirror_horizontal = n_mirror;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NBANK; i++) r_bank[i] <= bank_reset(3'(i));
            r_bank_sel    <= '0;
            r_ext_mode    <= '0;
            r_mirror      <= 1'b0;
            r_four_screen <= 1'b0;
            r_irq_cnt     <= '0;
            r_irq_reload  <= '0;
            r_irq_en      <= 1'b0;
            r_irq_blocked <= 1'b0;
            r_irq_line    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mirror      <= n_mirror;
            r_irq_cnt     <= n_irq_cnt;
            r_irq_en      <= n_irq_en;
            r_irq_blocked <= n_irq_blocked;
            r_irq_line    <= n_irq_line;
            if (i_cfg_wr_en && (i_cfg_index == CFG_FOUR_SCREEN)) r_four_screen <= i_cfg_wdata;
            if (o_take) begin
                case (i_item.op)
                    OP_EXT_WRITE:  r_ext_mode   <= i_item.data;
                    OP_BANK_SEL:   r_bank_sel   <= i_item.data;
                    OP_BANK_DATA:  r_bank[r_bank_sel[2:0]] <= i_item.data;
                    OP_IRQ_RELOAD: r_irq_reload <= i_item.data;
                    default:       r_ext_mode   <= r_ext_mode;
                endcase
            end
            if (o_take)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_out <= n_out;
    end

endmodule

// File: hw/rtl/mmc3_variant_bank_mapper_irq_top.sv
// channel   | dir | handshake                    | contents
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | command on tuser, bus fields on tdata
// m_axis    | out | m_axis_tvalid/m_axis_tready  | read, bank and status fields on tdata
// cfg       | in  | i_cfg_wr_en                  | four_screen (0), header mirroring (1)
//
// one item per clock sustained while m_axis_tready takes each result; a result passes through
// the front queue and then the back output register
// a two-entry queue parts decode from execution, so input takes two more items while an
// output waits, then drops ready until the output is taken
// synchronous active-low reset; no clearing pass, bank registers load their defaults at once
module mmc3_variant_bank_mapper_irq_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], data[23:16], scanline[32:24], display_on[33], zero pad
    input  logic [39:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], read_hit[8], prg_bank[12:9], chr_bank[20:13],
    // irq_pending[21], mirror_horizontal[22], zero pad
    output logic [23:0] m_axis_tdata
);
    import mmcv_pkg::*;

    t_item   front_item;
    t_item   q_item;
    t_result result;
    logic    q_full;
    logic    q_valid;
    logic    back_take;

    assign s_axis_tready = !q_full;

    mmcv_front u_front (
        .i_cmd        (s_axis_tuser),
        .i_addr       (s_axis_tdata[15:0]),
        .i_data       (s_axis_tdata[23:16]),
        .i_line       (s_axis_tdata[32:24]),
        .i_display_on (s_axis_tdata[33]),
        .o_item       (front_item)
    );

    mmcv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (back_take),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    mmcv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_take      (back_take),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule
